@@ rtl/core/hfbr_pkg.sv @@
// ----------------------------------------------------------------------------
// HID field to boot report package
// Shared constants, report types and small helper functions.
// ----------------------------------------------------------------------------
package hfbr_pkg;

    localparam int KEY_SLOT_COUNT = 6;
    localparam int SLOT_COUNT     = 8;
    localparam int KEY_BYTES      = 6;
    localparam int PACKED_KEYS    = (KEY_SLOT_COUNT < KEY_BYTES) ? KEY_SLOT_COUNT : KEY_BYTES;

    localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
    localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
    localparam logic [15:0] PAGE_BUTTON   = 16'h0009;
    localparam logic [15:0] MOD_FIRST     = 16'h00E0;
    localparam logic [15:0] MOD_LAST      = 16'h00E7;
    localparam logic [15:0] KEY_LIMIT     = 16'h0100;
    localparam logic [15:0] USE_X         = 16'h0030;
    localparam logic [15:0] USE_Y         = 16'h0031;
    localparam logic [15:0] USE_WHEEL     = 16'h0038;
    localparam logic [15:0] BUTTON_FIRST  = 16'h0001;
    localparam logic [15:0] BUTTON_LAST   = 16'h0008;

    localparam logic KIND_KEYBOARD = 1'b0;
    localparam logic KIND_MOUSE    = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [2:0]             slot;
        logic [7:0]             mods;
        logic [8*KEY_BYTES-1:0] keys;
        logic [7:0]             buttons;
        logic signed [7:0]      dx;
        logic signed [7:0]      dy;
        logic signed [7:0]      wheel;
        logic                   last;
    } t_report;

    typedef struct packed {
        logic    saw_keys;
        logic    saw_pointer;
        t_report kb;
        t_report ms;
    } t_snap;

    function automatic logic signed [7:0] sat8(input logic signed [31:0] v);
        logic signed [7:0] r;
        if (v > 32'sd127) begin
            r = 8'sd127;
        end else if (v < -32'sd128) begin
            r = -8'sd128;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] slot_wrap(input logic [2:0] s);
        int v;
        v = int'(s);
        for (int i = 0; i < 8; i++) begin
            if (v >= SLOT_COUNT) begin
                v = v - SLOT_COUNT;
            end
        end
        return v[2:0];
    endfunction

endpackage

@@ rtl/core/hid_fields_to_boot_reports_top.sv @@
// ----------------------------------------------------------------------------
// HID fields to boot reports, top level
// Builds boot-format keyboard and mouse reports from decoded HID fields.
// ----------------------------------------------------------------------------
// One field is accepted per cycle and folded into the accumulators in that
// cycle. The field marked last also loads the result holder, so it is only
// accepted when the holder is empty or drains its final report in the same
// cycle. A request that yields both a keyboard and a mouse report holds
// the output until both are handed out; all other fields are never stalled.
module hid_fields_to_boot_reports_top
    import hfbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_usage_page,
    input  logic [15:0]        i_usage_code,
    input  logic signed [31:0] i_field_value,
    input  logic [2:0]         i_device_slot,
    input  logic               i_last_field,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_report_kind,
    output logic [2:0]         o_out_slot,
    output logic [7:0]         o_modifier_bits,
    output logic [47:0]        o_key_codes,
    output logic [7:0]         o_button_bits,
    output logic signed [7:0]  o_delta_x,
    output logic signed [7:0]  o_delta_y,
    output logic signed [7:0]  o_wheel_delta,
    output logic               o_last_result
);

    logic    take;
    logic    holder_free;
    t_snap   snap;
    t_report report;

    assign o_in_ready = holder_free || !i_last_field;
    assign take       = i_in_valid && o_in_ready;

    hfbr_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_usage_page  (i_usage_page),
        .i_usage_code  (i_usage_code),
        .i_field_value (i_field_value),
        .i_device_slot (i_device_slot),
        .i_last_field  (i_last_field),
        .o_snap        (snap)
    );

    hfbr_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && i_last_field),
        .i_snap   (snap),
        .o_free   (holder_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_report (report)
    );

    assign o_report_kind   = report.kind;
    assign o_out_slot      = report.slot;
    assign o_modifier_bits = report.mods;
    assign o_key_codes     = report.keys;
    assign o_button_bits   = report.buttons;
    assign o_delta_x       = report.dx;
    assign o_delta_y       = report.dy;
    assign o_wheel_delta   = report.wheel;
    assign o_last_result   = report.last;

endmodule

@@ rtl/core/hfbr_accum.sv @@
// ----------------------------------------------------------------------------
// HID field accumulator
// Decodes one field per cycle, while fields are taken, into the keyboard and mouse accumulators and
// presents the finished reports as they stand after the current field.
// ----------------------------------------------------------------------------
module hfbr_accum
    import hfbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [15:0]        i_usage_page,
    input  logic [15:0]        i_usage_code,
    input  logic signed [31:0] i_field_value,
    input  logic [2:0]         i_device_slot,
    input  logic               i_last_field,
    output t_snap              o_snap
);

    logic [7:0]        r_mod,     n_mod;
    logic [7:0]        r_button,  n_button;
    logic signed [7:0] r_x,       n_x;
    logic signed [7:0] r_y,       n_y;
    logic signed [7:0] r_wheel,   n_wheel;
    logic              r_saw_key, n_saw_key;
    logic              r_saw_ptr, n_saw_ptr;
    logic [7:0]        r_slots [KEY_SLOT_COUNT];
    logic [7:0]        n_slots [KEY_SLOT_COUNT];

    logic is_mod;
    logic is_key;
    logic is_button;
    logic val_nz;
    logic hit;
    logic placed;
    logic [8*KEY_BYTES-1:0] keys;
    logic [2:0] slot;

    assign is_mod    = (i_usage_code >= MOD_FIRST) && (i_usage_code <= MOD_LAST);
    assign is_key    = (i_usage_code != 16'h0000) && (i_usage_code < KEY_LIMIT) && !is_mod;
    assign is_button = (i_usage_code >= BUTTON_FIRST) && (i_usage_code <= BUTTON_LAST);
    assign val_nz    = (i_field_value != 32'sd0);
    assign slot      = slot_wrap(i_device_slot);

    always_comb begin
        n_mod     = r_mod;
        n_button  = r_button;
        n_x       = r_x;
        n_y       = r_y;
        n_wheel   = r_wheel;
        n_saw_key = r_saw_key;
        n_saw_ptr = r_saw_ptr;
        n_slots   = r_slots;
        hit       = 1'b0;
        placed    = 1'b0;
        if (i_usage_page == PAGE_KEYBOARD) begin
            n_saw_key = 1'b1;
            if (is_mod && val_nz) begin
                n_mod = r_mod | (8'h01 << i_usage_code[2:0]);
            end
            if (is_key) begin
                for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                    if (r_slots[i] == i_usage_code[7:0]) begin
                        hit = 1'b1;
                    end
                end
                for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                    if (!hit && !placed && (r_slots[i] == 8'h00)) begin
                        n_slots[i] = i_usage_code[7:0];
                        placed     = 1'b1;
                    end
                end
            end
        end else if (i_usage_page == PAGE_BUTTON) begin
            if (is_button) begin
                n_saw_ptr = 1'b1;
                if (val_nz) begin
                    n_button = r_button | (8'h01 << 3'(i_usage_code[3:0] - 4'd1));
                end
            end
        end else if (i_usage_page == PAGE_DESKTOP) begin
            if (i_usage_code == USE_X) begin
                n_saw_ptr = 1'b1;
                n_x       = sat8(i_field_value);
            end else if (i_usage_code == USE_Y) begin
                n_saw_ptr = 1'b1;
                n_y       = sat8(i_field_value);
            end else if (i_usage_code == USE_WHEEL) begin
                n_saw_ptr = 1'b1;
                n_wheel   = sat8(i_field_value);
            end
        end
    end

    always_comb begin
        keys = '0;
        for (int i = 0; i < PACKED_KEYS; i++) begin
            keys[8*i +: 8] = n_slots[i];
        end
    end

    always_comb begin
        o_snap.saw_keys    = n_saw_key;
        o_snap.saw_pointer = n_saw_ptr;
        o_snap.kb          = '0;
        o_snap.kb.kind     = KIND_KEYBOARD;
        o_snap.kb.slot     = slot;
        o_snap.kb.mods     = n_mod;
        o_snap.kb.keys     = keys;
        o_snap.kb.last     = !n_saw_ptr;
        o_snap.ms          = '0;
        o_snap.ms.kind     = KIND_MOUSE;
        o_snap.ms.slot     = slot;
        o_snap.ms.buttons  = n_button;
        o_snap.ms.dx       = n_x;
        o_snap.ms.dy       = n_y;
        o_snap.ms.wheel    = n_wheel;
        o_snap.ms.last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_field)) begin
            r_mod     <= '0;
            r_button  <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_wheel   <= '0;
            r_saw_key <= 1'b0;
            r_saw_ptr <= 1'b0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_take) begin
            r_mod     <= n_mod;
            r_button  <= n_button;
            r_x       <= n_x;
            r_y       <= n_y;
            r_wheel   <= n_wheel;
            r_saw_key <= n_saw_key;
            r_saw_ptr <= n_saw_ptr;
            r_slots   <= n_slots;
        end
    end

endmodule

@@ rtl/core/hfbr_out.sv @@
// ----------------------------------------------------------------------------
// Boot report holder
// Holds the keyboard and mouse reports of one finished request and hands
// them out in order, keyboard first.
// ----------------------------------------------------------------------------
module hfbr_out
    import hfbr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_snap   i_snap,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_report o_report
);

    logic    r_kb_pend;
    logic    r_ms_pend;
    t_report r_kb;
    t_report r_ms;
    logic    pop;

    assign o_valid  = r_kb_pend || r_ms_pend;
    assign pop      = o_valid && i_ready;
    assign o_free   = !o_valid || (pop && (r_kb_pend != r_ms_pend));
    assign o_report = r_kb_pend ? r_kb : r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kb_pend <= 1'b0;
            r_ms_pend <= 1'b0;
        end else if (i_load) begin
            r_kb_pend <= i_snap.saw_keys;
            r_ms_pend <= i_snap.saw_pointer;
        end else if (pop) begin
            if (r_kb_pend) begin
                r_kb_pend <= 1'b0;
            end else begin
                r_ms_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kb <= i_snap.kb;
            r_ms <= i_snap.ms;
        end
    end

`ifndef SYNTHESIS
    a_kb_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kb_pend && r_ms_pend) |-> (o_report.kind == KIND_KEYBOARD && !o_report.last))
        else $error("keyboard report must precede mouse report and not be last");

    a_ms_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ms_pend && !r_kb_pend) |-> (o_report.kind == KIND_MOUSE && o_report.last))
        else $error("lone mouse report must be the last result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!o_valid || (pop && $countones({r_kb_pend, r_ms_pend}) == 1)))
        else $error("holder loaded while results still pending");

    a_mouse_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_report.kind == KIND_MOUSE) |-> (o_report.mods == 8'h00
            && o_report.keys == '0))
        else $error("mouse report carries keyboard data");
`endif

endmodule
